// ===== src/ufd_pkg.sv =====
`default_nettype none
package ufd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 8;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // register indexes on the configuration channel
  localparam cfg_idx_t REG_FIRST_HEADER = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SECOND_HEADER = cfg_idx_t'(1);
  localparam cfg_idx_t REG_MAX_FRAME_LEN = cfg_idx_t'(2);

  localparam byte_t FIRST_HEADER_RST = 8'hAA;
  localparam byte_t SECOND_HEADER_RST = 8'h55;
  localparam byte_t MAX_FRAME_LEN_RST = 8'd149;

  // lengths at or below this are rejected; also the offset of the first body byte
  localparam byte_t HDR_BYTES = 8'd3;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR2 = 2'd1,
    PH_LEN  = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  typedef struct packed {
    logic  is_end;
    byte_t body_byte;
    byte_t byte_offset;
    byte_t frame_len;
    logic  checksum_ok;
  } result_t;

endpackage
`default_nettype wire

// ===== src/ufd_if.sv =====
`default_nettype none
interface ufd_byte_if;
  import ufd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ufd_result_if;
  import ufd_pkg::*;
  logic  valid;
  logic  ready;
  logic  is_end;
  byte_t body_byte;
  byte_t byte_offset;
  byte_t frame_len;
  logic  checksum_ok;
  modport source (output valid, output is_end, output body_byte, output byte_offset,
                  output frame_len, output checksum_ok, input ready);
  modport sink (input valid, input is_end, input body_byte, input byte_offset,
                input frame_len, input checksum_ok, output ready);
endinterface

interface ufd_cfg_if;
  import ufd_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t idx;
  byte_t    data;
  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface
`default_nettype wire

// ===== src/uart_frame_deframer_xor.sv =====
`default_nettype none
// Channel    Port     Dir  Payload
// bytes in   in_ch    in   rx_byte
// results    out_ch   out  is_end, body_byte, byte_offset, frame_len, checksum_ok
// registers  cfg_ch   in   idx (0 first header, 1 second header, 2 max length), data
//
// One byte is taken per cycle; its result, if any, shows in the result register
// on the next cycle. The only stall is that register: while it holds a result
// that is not taken, in_ch.ready is low. The configuration channel is always ready.
// Synchronous active-low reset restores the register defaults and returns to hunting.
module uart_frame_deframer_xor (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ufd_byte_if.sink    in_ch,
  ufd_result_if.source out_ch,
  ufd_cfg_if.sink     cfg_ch
);
  import ufd_pkg::*;

  byte_t   first_hdr_r, second_hdr_r, max_len_r;
  phase_t  phase_r, phase_nxt;
  byte_t   len_r, len_nxt;
  byte_t   pos_r, pos_nxt;
  byte_t   xor_r, xor_nxt;
  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    res_fire;
  logic    in_xfer;
  logic    last_byte;
  byte_t   b;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign b            = in_ch.rx_byte;
  assign last_byte    = ({1'b0, pos_r} + 9'd1) >= {1'b0, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hdr_r  <= FIRST_HEADER_RST;
      second_hdr_r <= SECOND_HEADER_RST;
      max_len_r    <= MAX_FRAME_LEN_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        REG_FIRST_HEADER:  first_hdr_r  <= cfg_ch.data;
        REG_SECOND_HEADER: second_hdr_r <= cfg_ch.data;
        REG_MAX_FRAME_LEN: max_len_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    res_fire  = 1'b0;
    res_nxt   = '{is_end: 1'b0, body_byte: b, byte_offset: pos_r,
                  frame_len: len_r, checksum_ok: 1'b0};
    case (phase_r)
      PH_HUNT: begin
        if (b == first_hdr_r) begin
          xor_nxt   = b;
          phase_nxt = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (b == second_hdr_r) begin
          xor_nxt   = xor_r ^ b;
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (b <= HDR_BYTES || b > max_len_r) begin
          phase_nxt = PH_HUNT;
        end else begin
          len_nxt   = b;
          xor_nxt   = xor_r ^ b;
          pos_nxt   = HDR_BYTES;
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        res_fire = 1'b1;
        if (last_byte) begin
          res_nxt.is_end      = 1'b1;
          res_nxt.body_byte   = '0;
          res_nxt.checksum_ok = (b == xor_r);
          phase_nxt = PH_HUNT;
          len_nxt   = '0;
          pos_nxt   = '0;
          xor_nxt   = '0;
        end else begin
          xor_nxt = xor_r ^ b;
          pos_nxt = pos_r + 8'd1;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      pos_r   <= '0;
      xor_r   <= '0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
    end
  end

  // result register: load on a producing transfer, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_xfer && res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_end      = res_r.is_end;
  assign out_ch.body_byte   = res_r.body_byte;
  assign out_ch.byte_offset = res_r.byte_offset;
  assign out_ch.frame_len   = res_r.frame_len;
  assign out_ch.checksum_ok = res_r.checksum_ok;

  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && phase_r == PH_BODY && last_byte) |=> (phase_r == PH_HUNT))
    else $error("frame end did not return to hunting");

  a_body_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (len_r > HDR_BYTES && pos_r >= HDR_BYTES && pos_r < len_r))
    else $error("body position out of frame bounds");

  a_result_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.byte_offset >= HDR_BYTES && res_r.byte_offset < res_r.frame_len))
    else $error("result offset outside frame");

  a_body_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.is_end) |-> !res_r.checksum_ok)
    else $error("checksum flag set on body result");

endmodule
`default_nettype wire

// ===== tb/sv/tb_uart_frame_deframer_xor.sv =====
`default_nettype none
module tb_uart_frame_deframer_xor;
  import ufd_pkg::*;

  // indexes past the register file; writes to them must change nothing
  localparam cfg_idx_t REG_PAST_END = cfg_idx_t'(3);
  localparam cfg_idx_t REG_ALL_ONES = cfg_idx_t'(8'hFF);

  localparam result_t NO_RES = '0;

  typedef struct packed {
    byte_t   b;
    logic    typed;
    result_t res;
  } row_t;

  typedef struct {
    bit      typed;
    result_t res;
  } note_t;

  // directed bytes under the reset register values; result = {end, byte, off, len, ok}
  localparam int NUM_ROWS = 24;
  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    // shortest frame: checksum byte only
    '{8'hAA, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'h04, 1'b0, NO_RES},
    '{8'hFB, 1'b1, '{1'b1, 8'h00, 8'd3, 8'd4, 1'b1}},
    // one zero body byte, good checksum
    '{8'hAA, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'h05, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{1'b0, 8'h00, 8'd3, 8'd5, 1'b0}},
    '{8'hFA, 1'b1, '{1'b1, 8'h00, 8'd4, 8'd5, 1'b1}},
    // all-ones body byte, wrong checksum
    '{8'hAA, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'h05, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{1'b0, 8'hFF, 8'd3, 8'd5, 1'b0}},
    '{8'h00, 1'b1, '{1'b1, 8'h00, 8'd4, 8'd5, 1'b0}},
    // length too short
    '{8'hAA, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    // length one above the maximum
    '{8'hAA, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'h96, 1'b0, NO_RES},
    // bad second header; that byte must not restart the frame
    '{8'hAA, 1'b0, NO_RES},
    '{8'hAA, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'h04, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n;

  ufd_byte_if   in_if ();
  ufd_result_if out_if ();
  ufd_cfg_if    cfg_if ();

  uart_frame_deframer_xor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state and register copies
  phase_t scan_phase;
  byte_t  held_len;
  byte_t  next_off;
  byte_t  csum_acc;
  byte_t  want_hdr1;
  byte_t  want_hdr2;
  byte_t  len_limit;

  result_t expected_results [$];
  note_t   table_notes [$];

  int errors = 0;
  int bytes_in = 0;
  int bodies_seen = 0;
  int ends_seen = 0;
  int ends_good = 0;
  bit steady = 1'b0;

  function automatic bit deframe_byte(input byte_t b, output result_t r);
    bit hit;
    hit = 1'b0;
    r = '0;
    case (scan_phase)
      PH_HUNT: begin
        if (b == want_hdr1) begin
          csum_acc = b;
          scan_phase = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (b == want_hdr2) begin
          csum_acc = csum_acc ^ b;
          scan_phase = PH_LEN;
        end else begin
          scan_phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (b <= HDR_BYTES || b > len_limit) begin
          scan_phase = PH_HUNT;
        end else begin
          held_len = b;
          csum_acc = csum_acc ^ b;
          next_off = HDR_BYTES;
          scan_phase = PH_BODY;
        end
      end
      default: begin
        hit = 1'b1;
        r.byte_offset = next_off;
        r.frame_len = held_len;
        if ({1'b0, next_off} + 9'd1 >= {1'b0, held_len}) begin
          r.is_end = 1'b1;
          r.checksum_ok = (b == csum_acc);
          scan_phase = PH_HUNT;
          held_len = '0;
          next_off = '0;
          csum_acc = '0;
        end else begin
          r.body_byte = b;
          csum_acc = csum_acc ^ b;
          next_off = next_off + 8'd1;
        end
      end
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t act;
    result_t exp_r;
    result_t pred;
    note_t   nt;
    bit      got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        act.is_end = out_if.is_end;
        act.body_byte = out_if.body_byte;
        act.byte_offset = out_if.byte_offset;
        act.frame_len = out_if.frame_len;
        act.checksum_ok = out_if.checksum_ok;
        if (expected_results.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: end=%0d byte=%02h off=%0d len=%0d ok=%0d",
                     act.is_end, act.body_byte, act.byte_offset, act.frame_len,
                     act.checksum_ok);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (act.is_end !== exp_r.is_end || act.body_byte !== exp_r.body_byte ||
              act.byte_offset !== exp_r.byte_offset ||
              act.frame_len !== exp_r.frame_len ||
              act.checksum_ok !== exp_r.checksum_ok) begin
            if (errors < 10)
              $display("mismatch: expected end=%0d byte=%02h off=%0d len=%0d ok=%0d, got end=%0d byte=%02h off=%0d len=%0d ok=%0d",
                       exp_r.is_end, exp_r.body_byte, exp_r.byte_offset, exp_r.frame_len,
                       exp_r.checksum_ok, act.is_end, act.body_byte, act.byte_offset,
                       act.frame_len, act.checksum_ok);
            errors++;
          end
          if (exp_r.is_end) begin
            ends_seen++;
            if (exp_r.checksum_ok) ends_good++;
          end else begin
            bodies_seen++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        bytes_in++;
        nt.typed = 1'b0;
        nt.res = NO_RES;
        if (table_notes.size() != 0) nt = table_notes.pop_front();
        got = deframe_byte(in_if.rx_byte, pred);
        if (nt.typed) expected_results.push_back(nt.res);
        else if (got) expected_results.push_back(pred);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.idx)
          REG_FIRST_HEADER: want_hdr1 = cfg_if.data;
          REG_SECOND_HEADER: want_hdr2 = cfg_if.data;
          REG_MAX_FRAME_LEN: len_limit = cfg_if.data;
          default: ;
        endcase
      end
    end
  end

  // result side: random hold-off before each transfer, none while steady
  initial begin : result_sink
    int gap;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  task automatic send_byte(input byte_t b, input bit typed = 1'b0,
                           input result_t res = '0);
    int gap;
    note_t nt;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    nt.typed = typed;
    nt.res = res;
    table_notes.push_back(nt);
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // hold valid high across a batch; the caller drops it afterwards
  task automatic cfg_put(input cfg_idx_t idx, input byte_t d);
    cfg_if.valid <= 1'b1;
    cfg_if.idx <= idx;
    cfg_if.data <= d;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // drop valid and wait for the next clock edge so the register copies have taken the last write
  task automatic set_regs(input byte_t h1, input byte_t h2, input byte_t mx);
    cfg_put(REG_FIRST_HEADER, h1);
    cfg_put(REG_SECOND_HEADER, h2);
    cfg_put(REG_MAX_FRAME_LEN, mx);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, drain the results, then give the byte in flight time to land
  task automatic settle();
    int n;
    in_if.valid <= 1'b0;
    n = 0;
    @(posedge clk);
    while (expected_results.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_traffic(input int budget);
    int sent;
    int kind;
    int len;
    int lim;
    int n;
    byte_t x;
    byte_t b;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      lim = (len_limit < 8'd12) ? int'(len_limit) : 12;
      if (lim < 4) lim = 12;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        if (len_limit >= 8'd4 && $urandom_range(0, 29) == 0) len = int'(len_limit);
        else len = $urandom_range(4, lim);
        send_byte(want_hdr1);
        send_byte(want_hdr2);
        send_byte(byte_t'(len));
        x = want_hdr1 ^ want_hdr2 ^ byte_t'(len);
        for (int i = 3; i < len - 1; i++) begin
          b = byte_t'($urandom);
          send_byte(b);
          x = x ^ b;
        end
        if ($urandom_range(0, 3) == 0) x = byte_t'($urandom);
        send_byte(x);
        sent += len;
      end else if (kind < 82) begin
        case ($urandom_range(0, 2))
          0: begin
            send_byte(want_hdr1);
            send_byte(byte_t'($urandom));
            sent += 2;
          end
          1: begin
            if (len_limit == 8'hFF || $urandom_range(0, 1) == 0) len = $urandom_range(0, 3);
            else len = $urandom_range(int'(len_limit) + 1, 255);
            send_byte(want_hdr1);
            send_byte(want_hdr2);
            send_byte(byte_t'(len));
            sent += 3;
          end
          default: begin
            // cut short: the bytes that follow are taken as the rest of this frame
            len = $urandom_range(4, lim);
            send_byte(want_hdr1);
            send_byte(want_hdr2);
            send_byte(byte_t'(len));
            n = $urandom_range(0, len - 4);
            repeat (n) send_byte(byte_t'($urandom));
            sent += 3 + n;
          end
        endcase
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(byte_t'($urandom));
        sent += n;
      end
    end
  endtask

  initial begin : stimulus
    scan_phase = PH_HUNT;
    held_len = '0;
    next_off = '0;
    csum_acc = '0;
    want_hdr1 = FIRST_HEADER_RST;
    want_hdr2 = SECOND_HEADER_RST;
    len_limit = MAX_FRAME_LEN_RST;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.rx_byte <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.idx <= '0;
    cfg_if.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++)
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    run_traffic(400);

    settle();
    set_regs(8'h00, 8'hFF, 8'd4);
    run_traffic(300);

    settle();
    set_regs(8'hFF, 8'h00, 8'd255);
    run_traffic(400);

    settle();
    set_regs(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom_range(4, 255)));
    run_traffic(400);

    settle();
    set_regs(8'h5A, 8'h5A, 8'd20);
    run_traffic(200);

    // maximum below the shortest frame: nothing gets through
    settle();
    set_regs(FIRST_HEADER_RST, SECOND_HEADER_RST, 8'd3);
    run_traffic(60);

    settle();
    cfg_put(REG_MAX_FRAME_LEN, MAX_FRAME_LEN_RST);
    cfg_put(REG_PAST_END, 8'h04);
    cfg_put(REG_ALL_ONES, 8'h10);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    run_traffic(250);

    settle();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      errors += expected_results.size();
    end

    $display("sent %0d bytes over seven register settings; %0d body bytes and %0d frame ends",
             bytes_in, bodies_seen, ends_seen);
    $display("%0d frame ends carried a good checksum; %0d failures", ends_good, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
